// File: rtl/core/vertex_rotate_scale_clip_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the vertex rotate / scale / clip block
// Implication checks disabled while active-low reset is asserted; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef VERTEX_ROTATE_SCALE_CLIP_MACROS_SVH
`define VERTEX_ROTATE_SCALE_CLIP_MACROS_SVH

`ifndef SYNTHESIS
`define VRSC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("vrsc assertion failed");
`define VRSC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("vrsc assertion failed");
`else
`define VRSC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define VRSC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/core/vrsc_pkg.sv
// ----------------------------------------------------------------------------
// vrsc_pkg
// Types, register codes, sine table and fixed-point helpers for the vertex
// rotate / scale / clip block.
// ----------------------------------------------------------------------------
package vrsc_pkg;

    // register indexes on the configuration port
    typedef enum logic [1:0] {
        CFG_SCALE = 2'd0,
        CFG_ANGLE = 2'd1,
        CFG_POS_X = 2'd2,
        CFG_POS_Y = 2'd3
    } t_cfg_idx;

    localparam int CFG_DATA_W = 13;
    localparam logic [11:0] SCALE_RESET = 12'd256;

    typedef struct packed {
        logic        [11:0] scale;
        logic        [8:0]  angle;
        logic signed [12:0] pos_x;
        logic signed [12:0] pos_y;
    } t_cfg;

    // scaled vertex as it crosses from front to back
    typedef struct packed {
        logic signed [7:0] sx;
        logic signed [7:0] sy;
        logic              first;
    } t_vtx;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_X,
        S_MUL_Y,
        S_ROT_Y,
        S_EMIT
    } t_state;

    // quarter-wave sine, Q1.14
    localparam logic [14:0] SIN_Q14 [0:90] = '{
        15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,  15'd1428,  15'd1713,
        15'd1997,  15'd2280,  15'd2563,  15'd2845,  15'd3126,  15'd3406,  15'd3686,
        15'd3964,  15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,  15'd5604,
        15'd5872,  15'd6138,  15'd6402,  15'd6664,  15'd6924,  15'd7182,  15'd7438,
        15'd7692,  15'd7943,  15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
        15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311, 15'd10531, 15'd10749,
        15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176,
        15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255, 15'd13421,
        15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330, 15'd14466,
        15'd14598, 15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
        15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897,
        15'd15964, 15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262,
        15'd16294, 15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
    };

    function automatic logic signed [7:0] sat8(input logic signed [15:0] v);
        logic signed [7:0] r;
        if (v > 16'sd127) begin
            r = 8'sd127;
        end else if (v < -16'sd128) begin
            r = -8'sd128;
        end else begin
            r = 8'(v);
        end
        return r;
    endfunction

    // vertex * Q4.8 scale, truncated toward zero, saturated
    function automatic logic signed [7:0] scale_vtx(input logic signed [7:0] v,
                                                    input logic [11:0] sf);
        logic signed [20:0] p;
        logic signed [20:0] b;
        p = 21'(v) * 21'($signed({1'b0, sf}));
        b = p + (p[20] ? 21'sd255 : 21'sd0);
        return sat8(16'(b >>> 8));
    endfunction

    // Q1.14 rotation sum back to integer, truncated toward zero, saturated
    function automatic logic signed [7:0] rot_trunc(input logic signed [24:0] p);
        logic signed [24:0] b;
        b = p + (p[24] ? 25'sd16383 : 25'sd0);
        return sat8(16'(b >>> 14));
    endfunction

    // angle already reduced below 360
    function automatic logic signed [15:0] sine_fold(input logic [8:0] a);
        logic [8:0]         k;
        logic               neg;
        logic signed [15:0] m;
        if (a <= 9'd90) begin
            k   = a;
            neg = 1'b0;
        end else if (a <= 9'd180) begin
            k   = 9'd180 - a;
            neg = 1'b0;
        end else if (a <= 9'd270) begin
            k   = a - 9'd180;
            neg = 1'b1;
        end else begin
            k   = 9'd360 - a;
            neg = 1'b1;
        end
        m = $signed({1'b0, SIN_Q14[k[6:0]]});
        return neg ? -m : m;
    endfunction

    function automatic logic [8:0] mod360(input logic [9:0] a);
        return (a >= 10'd360) ? 9'(a - 10'd360) : a[8:0];
    endfunction

endpackage

// File: rtl/core/vrsc_front.sv
// ----------------------------------------------------------------------------
// vrsc_front
// Accepts vertices, applies the model scale and queues the scaled vertex.
// ----------------------------------------------------------------------------
module vrsc_front (
    input  logic              i_valid,
    output logic              o_ready,
    input  logic signed [7:0] i_vertex_x,
    input  logic signed [7:0] i_vertex_y,
    input  logic              i_first_of_model,
    input  logic [11:0]       i_scale,
    input  logic              i_q_full,
    output logic              o_push,
    output vrsc_pkg::t_vtx    o_ent
);
    import vrsc_pkg::*;

    assign o_ready     = !i_q_full;
    assign o_push      = i_valid && !i_q_full;
    assign o_ent.sx    = scale_vtx(i_vertex_x, i_scale);
    assign o_ent.sy    = scale_vtx(i_vertex_y, i_scale);
    assign o_ent.first = i_first_of_model;

endmodule

// File: rtl/core/vrsc_fifo.sv
// ----------------------------------------------------------------------------
// vrsc_fifo
// Short queue of scaled vertices between front and back.
// ----------------------------------------------------------------------------
module vrsc_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  vrsc_pkg::t_vtx i_ent,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output vrsc_pkg::t_vtx o_ent
);
    import vrsc_pkg::*;

    t_vtx              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp, n_wp;
    logic [QPTR_W-1:0] r_rp, n_rp;
    logic [QPTR_W:0]   r_cnt, n_cnt;

    always_comb begin
        n_wp  = r_wp + QPTR_W'(i_push);
        n_rp  = r_rp + QPTR_W'(i_pop);
        n_cnt = r_cnt + (QPTR_W+1)'(i_push) - (QPTR_W+1)'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_ent;
        end
    end

    assign o_full  = (r_cnt == (QPTR_W+1)'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_ent   = r_mem[r_rp];

endmodule

// File: rtl/core/vrsc_back.sv
// ----------------------------------------------------------------------------
// vrsc_back
// Rotates, translates and clamps one queued vertex at a time; tracks edge
// touches per model and holds the result in an output register.
// ----------------------------------------------------------------------------
`include "vertex_rotate_scale_clip_macros.svh"

module vrsc_back #(
    parameter int SCREEN_MAX_X = 239,
    parameter int SCREEN_MAX_Y = 159
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  vrsc_pkg::t_cfg i_cfg,
    input  logic           i_q_valid,
    input  vrsc_pkg::t_vtx i_q_ent,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [7:0]     o_screen_x,
    output logic [7:0]     o_screen_y,
    output logic           o_edge_touch,
    output logic           o_bounce
);
    import vrsc_pkg::*;

    localparam logic signed [17:0] LimX = 18'(SCREEN_MAX_X * 16);
    localparam logic signed [17:0] LimY = 18'(SCREEN_MAX_Y * 16);
    localparam logic [7:0]         MaxX8 = 8'(SCREEN_MAX_X);
    localparam logic [7:0]         MaxY8 = 8'(SCREEN_MAX_Y);

    t_state             r_state, n_state;
    t_vtx               r_vtx;
    logic signed [15:0] r_sin, r_cos;
    logic signed [23:0] r_pa, r_pb;
    logic signed [7:0]  r_rx, r_ry;
    logic               r_touched;
    logic               r_out_valid;
    logic [7:0]         r_out_x, r_out_y;
    logic               r_out_edge, r_out_bounce;

    logic               w_load;
    logic [8:0]         w_ang;
    logic signed [17:0] w_xq, w_yq;
    logic               w_edge;
    logic [7:0]         w_ox, w_oy;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_q_valid) n_state = S_MUL_X;
            S_MUL_X: n_state = S_MUL_Y;
            S_MUL_Y: n_state = S_ROT_Y;
            S_ROT_Y: n_state = S_EMIT;
            S_EMIT:  if (!r_out_valid || i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_pop  = 1'b0;
        w_load = 1'b0;
        unique case (r_state)
            S_IDLE:  o_pop  = i_q_valid;
            S_EMIT:  w_load = !r_out_valid || i_ready;
            default: ;
        endcase
    end

    assign w_ang = mod360({1'b0, i_cfg.angle});

    // translate to Q.4 screen space and clamp
    always_comb begin
        w_xq = 18'(16'(r_rx) * 16'sd16) + 18'(i_cfg.pos_x);
        w_yq = 18'(16'(r_ry) * 16'sd16) + 18'(i_cfg.pos_y);
        w_edge = (w_xq <= 18'sd0) || (w_xq >= LimX) ||
                 (w_yq <= 18'sd0) || (w_yq >= LimY);
        if (w_xq < 18'sd0) begin
            w_ox = '0;
        end else if (w_xq > LimX) begin
            w_ox = MaxX8;
        end else begin
            w_ox = w_xq[11:4];
        end
        if (w_yq < 18'sd0) begin
            w_oy = '0;
        end else if (w_yq > LimY) begin
            w_oy = MaxY8;
        end else begin
            w_oy = w_yq[11:4];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_touched   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
                r_touched   <= w_edge || (r_touched && !r_vtx.first);
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_vtx <= i_q_ent;
            r_sin <= sine_fold(w_ang);
            r_cos <= sine_fold(mod360(10'(w_ang) + 10'd90));
        end
        unique case (r_state)
            S_MUL_X: begin
                r_pa <= 24'(r_cos) * 24'(r_vtx.sx);
                r_pb <= 24'(r_sin) * 24'(r_vtx.sy);
            end
            S_MUL_Y: begin
                r_rx <= rot_trunc(25'(r_pa) - 25'(r_pb));
                r_pa <= 24'(r_sin) * 24'(r_vtx.sx);
                r_pb <= 24'(r_cos) * 24'(r_vtx.sy);
            end
            S_ROT_Y: begin
                r_ry <= rot_trunc(25'(r_pa) + 25'(r_pb));
            end
            default: ;
        endcase
        if (w_load) begin
            r_out_x      <= w_ox;
            r_out_y      <= w_oy;
            r_out_edge   <= w_edge;
            r_out_bounce <= w_edge && (r_vtx.first || !r_touched);
        end
    end

    assign o_valid      = r_out_valid;
    assign o_screen_x   = r_out_x;
    assign o_screen_y   = r_out_y;
    assign o_edge_touch = r_out_edge;
    assign o_bounce     = r_out_bounce;

    `VRSC_ASSERT_IMP(a_bounce_needs_edge, i_clk, i_rst_n, o_valid && o_bounce, o_edge_touch)
    `VRSC_ASSERT_NXT(a_edge_marks_touched, i_clk, i_rst_n, w_load && w_edge, r_touched)
    `VRSC_ASSERT_NXT(a_pop_starts_rotate, i_clk, i_rst_n, o_pop, r_state == S_MUL_X)

endmodule

// File: rtl/core/vertex_rotate_scale_clip.sv
// ----------------------------------------------------------------------------
// vertex_rotate_scale_clip
// Scales, rotates, translates and clamps model vertices to the screen.
// ----------------------------------------------------------------------------
// A vertex is scaled in the cycle it is accepted and written into a
// two-entry queue, so input is taken while the back end works or a result
// waits. The back end works on one vertex at a time, in steps: a pop step that
// looks up sine and cosine, two multiply steps each using a pair of 16x8
// multipliers, a truncate step, then translate and clamp into the output
// register; it pops the next vertex only after that load, which waits while a
// held result has not been taken. Registers are to be written through the
// configuration port only while no vertex is in flight; the block itself does
// not enforce this.
// ----------------------------------------------------------------------------
module vertex_rotate_scale_clip #(
    parameter int SCREEN_MAX_X = 239,
    parameter int SCREEN_MAX_Y = 159
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [1:0]                       i_cfg_idx,
    input  logic [vrsc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic signed [7:0]                i_vertex_x,
    input  logic signed [7:0]                i_vertex_y,
    input  logic                             i_first_of_model,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [7:0]                       o_screen_x,
    output logic [7:0]                       o_screen_y,
    output logic                             o_edge_touch,
    output logic                             o_bounce
);
    import vrsc_pkg::*;

    t_cfg r_cfg;
    logic w_push, w_full, w_pop, w_qv;
    t_vtx w_in_ent, w_q_ent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.scale <= SCALE_RESET;
            r_cfg.angle <= '0;
            r_cfg.pos_x <= '0;
            r_cfg.pos_y <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SCALE: r_cfg.scale <= i_cfg_data[11:0];
                CFG_ANGLE: r_cfg.angle <= i_cfg_data[8:0];
                CFG_POS_X: r_cfg.pos_x <= $signed(i_cfg_data);
                CFG_POS_Y: r_cfg.pos_y <= $signed(i_cfg_data);
                default:   ;
            endcase
        end
    end

    vrsc_front u_front (
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_vertex_x       (i_vertex_x),
        .i_vertex_y       (i_vertex_y),
        .i_first_of_model (i_first_of_model),
        .i_scale          (r_cfg.scale),
        .i_q_full         (w_full),
        .o_push           (w_push),
        .o_ent            (w_in_ent)
    );

    vrsc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_ent   (w_in_ent),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_qv),
        .o_ent   (w_q_ent)
    );

    vrsc_back #(
        .SCREEN_MAX_X (SCREEN_MAX_X),
        .SCREEN_MAX_Y (SCREEN_MAX_Y)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_q_valid    (w_qv),
        .i_q_ent      (w_q_ent),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_screen_x   (o_screen_x),
        .o_screen_y   (o_screen_y),
        .o_edge_touch (o_edge_touch),
        .o_bounce     (o_bounce)
    );

endmodule
